// ===== rtl/core/binary_trie_max_xor_core_defines.svh =====
// assertion helpers shared by the trie core
`ifndef BINARY_TRIE_MAX_XOR_CORE_DEFINES_SVH
`define BINARY_TRIE_MAX_XOR_CORE_DEFINES_SVH

// same-cycle implication
`define BTMX_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BTMX_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/btmx_pkg.sv =====
`timescale 1ns / 1ps
package btmx_pkg;

    localparam int unsigned KEY_W         = 31;
    localparam int unsigned DATA_W        = 32;
    localparam int unsigned FUNC_W        = 2;
    localparam int unsigned STAT_W        = 2;
    localparam int unsigned CNT_W         = 32;
    localparam int unsigned DEF_KEY_BITS  = 31;
    localparam int unsigned DEF_MAX_NODES = 65536;

    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR  = 2'd0,
        FN_INSERT = 2'd1,
        FN_DELETE = 2'd2,
        FN_QUERY  = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_store_req;

endpackage

// ===== rtl/core/btmx_node_store.sv =====
`timescale 1ns / 1ps
module btmx_node_store #(
    parameter int unsigned DEPTH = btmx_pkg::DEF_MAX_NODES,
    parameter int unsigned AW    = $clog2(DEPTH),
    parameter int unsigned EW    = 2 * AW + btmx_pkg::CNT_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  btmx_pkg::t_store_req  i_req,
    input  logic [AW-1:0]         i_rd_addr,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [EW-1:0]         i_wr_data,
    output logic [EW-1:0]         o_rd_data,
    output logic [EW-1:0]         o_root
);
    import btmx_pkg::*;

    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_q;
    logic [EW-1:0] r_root;
    logic          r_q_root;

    // node entries, root lives in flops
    always_ff @(posedge i_clk) begin
        if (i_req.wr && (i_wr_addr != '0)) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_req.rd) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root   <= '0;
            r_q_root <= 1'b0;
        end else begin
            if (i_req.wr && (i_wr_addr == '0)) begin
                r_root <= i_wr_data;
            end
            if (i_req.rd) begin
                r_q_root <= (i_rd_addr == '0);
            end
        end
    end

    assign o_rd_data = r_q_root ? r_root : r_q;
    assign o_root    = r_root;

endmodule

// ===== rtl/core/binary_trie_max_xor_core.sv =====
`timescale 1ns / 1ps
`include "binary_trie_max_xor_core_defines.svh"
// one request at a time; a new request is taken once the previous one has left the walk
// clear: root entry written, then finish; insert/delete: check walk, then update walk
// query: one or two child reads per trie level, through the single node memory read port
// result waits in an output register; the next request is taken while it waits
// reset empties the trie at once (root in flops, node count zero); no memory clearing pass
module binary_trie_max_xor_core #(
    parameter int unsigned KEY_BITS  = btmx_pkg::DEF_KEY_BITS,
    parameter int unsigned MAX_NODES = btmx_pkg::DEF_MAX_NODES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [btmx_pkg::DATA_W-1:0]  i_s_axis_tdata,  // key
    input  logic [btmx_pkg::FUNC_W-1:0]  i_s_axis_tuser,  // func
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [btmx_pkg::DATA_W-1:0]  o_m_axis_tdata,  // match_key
    output logic [btmx_pkg::STAT_W-1:0]  o_m_axis_tuser   // status
);
    import btmx_pkg::*;

    localparam int unsigned NW = $clog2(MAX_NODES);
    localparam int unsigned EW = 2 * NW + CNT_W;
    localparam int unsigned LW = $clog2(KEY_BITS + 1);

    typedef struct packed {
        logic [NW-1:0]    link1;
        logic [NW-1:0]    link0;
        logic [CNT_W-1:0] cnt;
    } t_node;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_WALK = 6'b000010,
        S_UPD  = 6'b000100,
        S_QRY  = 6'b001000,
        S_QCHK = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    t_func             r_op, n_op;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [KEY_BITS-1:0] r_sh, n_sh;
    logic [KEY_BITS-1:0] r_res, n_res;
    logic [LW-1:0]     r_lvl, n_lvl;
    logic [NW-1:0]     r_p, n_p;
    logic [NW-1:0]     r_used, n_used;
    logic [NW-1:0]     r_alt, n_alt;
    logic              r_fresh, n_fresh;
    logic              r_tb, n_tb;
    t_status           r_status, n_status;
    logic              r_ovalid;
    logic [KEY_W-1:0]  r_out_key;
    t_status           r_out_status;

    t_store_req        w_req;
    logic [NW-1:0]     w_rd_addr;
    logic [NW-1:0]     w_wr_addr;
    logic [EW-1:0]     w_wr_data;
    logic [EW-1:0]     w_rd_raw;
    logic [EW-1:0]     w_root_raw;
    t_node             w_root;
    t_node             w_cur;
    t_node             w_upd;
    logic              w_msb;
    logic              w_want;
    logic [NW-1:0]     w_child;
    logic [NW-1:0]     w_a;
    logic [NW-1:0]     w_b;
    logic [NW-1:0]     w_new;
    logic [NW:0]       w_need;
    logic              w_full;
    logic              w_in_acc;
    logic              w_out_free;

    btmx_node_store #(
        .DEPTH (MAX_NODES),
        .AW    (NW),
        .EW    (EW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .i_rd_addr (w_rd_addr),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_raw),
        .o_root    (w_root_raw)
    );

    assign w_root     = t_node'(w_root_raw);
    assign w_cur      = r_fresh ? t_node'('0) : t_node'(w_rd_raw);
    assign w_msb      = r_sh[KEY_BITS-1];
    assign w_want     = ~w_msb;
    assign w_child    = w_msb ? w_cur.link1 : w_cur.link0;
    assign w_a        = w_want ? w_cur.link1 : w_cur.link0;
    assign w_b        = w_want ? w_cur.link0 : w_cur.link1;
    assign w_new      = r_used + 1'b1;
    assign w_need     = {1'b0, r_used} + (NW+1)'(r_lvl);
    assign w_full     = w_need > (NW+1)'(MAX_NODES - 1);
    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_ovalid || i_m_axis_tready;

    // count update, and link to a newly taken node
    always_comb begin
        w_upd = w_cur;
        if (r_op == FN_INSERT) begin
            w_upd.cnt = w_cur.cnt + 1'b1;
        end else begin
            w_upd.cnt = w_cur.cnt - 1'b1;
        end
        if ((r_lvl != '0) && (w_child == '0)) begin
            if (w_msb) begin
                w_upd.link1 = w_new;
            end else begin
                w_upd.link0 = w_new;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_key     = r_key;
        n_sh      = r_sh;
        n_res     = r_res;
        n_lvl     = r_lvl;
        n_p       = r_p;
        n_used    = r_used;
        n_alt     = r_alt;
        n_fresh   = r_fresh;
        n_tb      = r_tb;
        n_status  = r_status;
        w_req     = '0;
        w_rd_addr = '0;
        w_wr_addr = r_p;
        w_wr_data = EW'(w_upd);

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_op     = t_func'(i_s_axis_tuser);
                    n_key    = KEY_BITS'(i_s_axis_tdata[KEY_W-1:0]);
                    n_sh     = KEY_BITS'(i_s_axis_tdata[KEY_W-1:0]);
                    n_res    = '0;
                    n_status = ST_OK;
                    n_lvl    = LW'(KEY_BITS);
                    n_fresh  = 1'b0;
                    n_p      = '0;
                    unique case (t_func'(i_s_axis_tuser))
                        FN_CLEAR: begin
                            w_req.wr  = 1'b1;
                            w_wr_addr = '0;
                            w_wr_data = '0;
                            n_used    = '0;
                            n_state   = S_FIN;
                        end
                        FN_INSERT: begin
                            if (w_root.cnt == '1) begin
                                n_status = ST_FULL;
                                n_state  = S_FIN;
                            end else begin
                                w_req.rd = 1'b1;
                                n_state  = S_WALK;
                            end
                        end
                        FN_DELETE: begin
                            w_req.rd = 1'b1;
                            n_state  = S_WALK;
                        end
                        FN_QUERY: begin
                            if (w_root.cnt == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_FIN;
                            end else begin
                                w_req.rd = 1'b1;
                                n_state  = S_QRY;
                            end
                        end
                    endcase
                end
            end
            S_WALK: begin
                priority if ((r_lvl == '0) && (r_op == FN_DELETE) && (w_cur.cnt == '0)) begin
                    n_status = ST_EMPTY;
                    n_state  = S_FIN;
                end else if ((r_lvl != '0) && (w_child == '0) && (r_op != FN_INSERT)) begin
                    n_status = ST_EMPTY;
                    n_state  = S_FIN;
                end else if ((r_lvl != '0) && (w_child == '0) && w_full) begin
                    n_status = ST_FULL;
                    n_state  = S_FIN;
                end else if ((r_lvl == '0) || (w_child == '0)) begin
                    // path checked, start the update walk from the root
                    w_req.rd = 1'b1;
                    n_p      = '0;
                    n_lvl    = LW'(KEY_BITS);
                    n_sh     = r_key;
                    n_fresh  = 1'b0;
                    n_state  = S_UPD;
                end else begin
                    w_req.rd  = 1'b1;
                    w_rd_addr = w_child;
                    n_lvl     = r_lvl - 1'b1;
                    n_sh      = r_sh << 1;
                end
            end
            S_UPD: begin
                w_req.wr = 1'b1;
                if (r_lvl == '0) begin
                    n_state = S_FIN;
                end else begin
                    if (w_child == '0) begin
                        n_used  = w_new;
                        n_p     = w_new;
                        n_fresh = 1'b1;
                    end else begin
                        w_req.rd  = 1'b1;
                        w_rd_addr = w_child;
                        n_p       = w_child;
                        n_fresh   = 1'b0;
                    end
                    n_lvl = r_lvl - 1'b1;
                    n_sh  = r_sh << 1;
                end
            end
            S_QRY: begin
                n_alt = w_b;
                priority if (w_a != '0) begin
                    w_req.rd  = 1'b1;
                    w_rd_addr = w_a;
                    n_tb      = 1'b0;
                    n_state   = S_QCHK;
                end else if (w_b != '0) begin
                    w_req.rd  = 1'b1;
                    w_rd_addr = w_b;
                    n_tb      = 1'b1;
                    n_state   = S_QCHK;
                end else begin
                    n_status = ST_EMPTY;
                    n_state  = S_FIN;
                end
            end
            S_QCHK: begin
                priority if (w_cur.cnt != '0) begin
                    n_res = KEY_BITS'({r_res, w_want ^ r_tb});
                    n_lvl = r_lvl - 1'b1;
                    n_sh  = r_sh << 1;
                    if (r_lvl == LW'(1)) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_QRY;
                    end
                end else if (!r_tb && (r_alt != '0)) begin
                    w_req.rd  = 1'b1;
                    w_rd_addr = r_alt;
                    n_tb      = 1'b1;
                end else begin
                    n_status = ST_EMPTY;
                    n_state  = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_fresh <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_fresh <= n_fresh;
            if ((r_state == S_FIN) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_sh     <= n_sh;
        r_res    <= n_res;
        r_lvl    <= n_lvl;
        r_p      <= n_p;
        r_alt    <= n_alt;
        r_tb     <= n_tb;
        r_status <= n_status;
        if ((r_state == S_FIN) && w_out_free) begin
            r_out_key    <= (r_status == ST_OK) ? KEY_W'(r_res) : '0;
            r_out_status <= r_status;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = DATA_W'(r_out_key);
    assign o_m_axis_tuser  = r_out_status;

    `BTMX_ASSERT_IMP(a_no_rw_same_entry, w_req.rd && w_req.wr, w_rd_addr != w_wr_addr, "node read and write collide")
    `BTMX_ASSERT_NXT(a_one_request, w_in_acc, !o_s_axis_tready, "second request taken during a walk")
    `BTMX_ASSERT_IMP(a_result_from_fin, $rose(o_m_axis_tvalid), $past(r_state == S_FIN), "result without finish")

endmodule
